// ----- hdl/sse_pkg.sv -----
// sse_pkg: field widths, action codes and status codes for the sparse set engine.
// No dependencies; imported by the top level.
package sse_pkg;

    localparam int ACT_W  = 3;
    localparam int KEY_W  = 10;
    localparam int POS_W  = 8;
    localparam int SLOT_W = 8;
    localparam int CNT_W  = 9;
    localparam int STAT_W = 2;

    typedef logic [ACT_W-1:0]  action_t;
    typedef logic [KEY_W-1:0]  key_t;
    typedef logic [STAT_W-1:0] status_t;

    localparam action_t ACT_SEARCH = 3'd0;
    localparam action_t ACT_INSERT = 3'd1;
    localparam action_t ACT_REMOVE = 3'd2;
    localparam action_t ACT_READ   = 3'd3;
    localparam action_t ACT_CLEAR  = 3'd4;

    localparam status_t ST_DONE   = 2'd0;
    localparam status_t ST_NOEFF  = 2'd1;
    localparam status_t ST_REJECT = 2'd2;

endpackage

// ----- hdl/sse_ram.sv -----
// sse_ram: generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; used for both stores of the sparse set engine.
module sse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/sparse_set_engine_unit.sv -----
// sparse_set_engine_unit: sparse set of keys held in a dense member store and a
// key-to-slot store, one action per word. Depends on sse_pkg and sse_ram.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+----------------------------------
//   in      | input     | in_valid / in_stall  | action, key, position
//   out     | output    | out_valid / out_stall| found, slot, key_out, count, status
//
// The result is registered after accept via S_LOOK and S_DONE for read, clear, out-of-range
// keys and unused actions, via S_LOOK, S_CHK, S_RM and S_DONE for a remove that hits, and via
// S_LOOK, S_CHK and S_DONE for every other search, insert or remove (one memory read per step;
// a hitting remove needs a third, dependent read of the dense store). The next word is taken
// the cycle after the result is loaded; no new word is taken while one is in flight.
// After reset the key-to-slot store is swept to zero with the input stalled.
// A result waiting on out_stall holds the engine in its final step.
module sparse_set_engine_unit
    import sse_pkg::*;
#(
    parameter int KEY_LIMIT = 1024,
    parameter int CAPACITY  = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [ACT_W-1:0]  action,
    input  logic [KEY_W-1:0]  key,
    input  logic [POS_W-1:0]  position,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              found,
    output logic [SLOT_W-1:0] slot,
    output logic [KEY_W-1:0]  key_out,
    output logic [CNT_W-1:0]  count,
    output logic [STAT_W-1:0] status
);

    localparam int KIW = $clog2(KEY_LIMIT);
    localparam int SW  = $clog2(CAPACITY);
    localparam int NW  = $clog2(CAPACITY + 1);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_LOOK = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_RM   = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [KIW-1:0]    clr_idx_reg, clr_idx_next;
    logic [NW-1:0]     cnt_reg, cnt_next;
    action_t           act_reg, act_next;
    key_t              key_reg, key_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [SW-1:0]     s_reg, s_next;

    logic              r_found_reg, r_found_next;
    logic [SLOT_W-1:0] r_slot_reg, r_slot_next;
    key_t              r_key_reg, r_key_next;
    status_t           r_status_reg, r_status_next;

    logic              out_valid_reg, out_valid_next;
    logic              found_reg, found_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    key_t              key_out_reg, key_out_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    status_t           status_reg, status_next;

    logic              sp_we;
    logic [KIW-1:0]    sp_waddr, sp_raddr;
    logic [SW-1:0]     sp_wdata, sp_rdata;
    logic              dn_we;
    logic [SW-1:0]     dn_waddr, dn_raddr;
    key_t              dn_wdata, dn_rdata;

    logic              accept;
    logic              key_oor;
    logic              hit;
    logic              out_free;

    sse_ram #(.WIDTH(SW), .DEPTH(KEY_LIMIT)) u_sparse (
        .clk   (clk),
        .we    (sp_we),
        .waddr (sp_waddr),
        .wdata (sp_wdata),
        .raddr (sp_raddr),
        .rdata (sp_rdata)
    );

    sse_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_dense (
        .clk   (clk),
        .we    (dn_we),
        .waddr (dn_waddr),
        .wdata (dn_wdata),
        .raddr (dn_raddr),
        .rdata (dn_rdata)
    );

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign key_oor  = (32'(key_reg) >= KEY_LIMIT);
    // membership is confirmed against the dense list, stale map entries miss here
    assign hit      = (NW'(s_reg) < cnt_reg) && (dn_rdata == key_reg);
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        clr_idx_next   = clr_idx_reg;
        cnt_next       = cnt_reg;
        act_next       = act_reg;
        key_next       = key_reg;
        pos_next       = pos_reg;
        s_next         = s_reg;
        r_found_next   = r_found_reg;
        r_slot_next    = r_slot_reg;
        r_key_next     = r_key_reg;
        r_status_next  = r_status_reg;
        out_valid_next = out_valid_reg && out_stall;
        found_next     = found_reg;
        slot_next      = slot_reg;
        key_out_next   = key_out_reg;
        count_next     = count_reg;
        status_next    = status_reg;

        sp_we    = 1'b0;
        sp_waddr = KIW'(key_reg);
        sp_wdata = SW'(cnt_reg);
        sp_raddr = KIW'(key_reg);
        dn_we    = 1'b0;
        dn_waddr = SW'(cnt_reg);
        dn_wdata = key_reg;
        dn_raddr = SW'(pos_reg);

        unique case (state_reg)
            S_CLR:
            begin
                sp_we    = 1'b1;
                sp_waddr = clr_idx_reg;
                sp_wdata = '0;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == KIW'(KEY_LIMIT - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                sp_raddr = KIW'(key);
                dn_raddr = SW'(position);
                if (accept)
                begin
                    act_next      = action;
                    key_next      = key;
                    pos_next      = position;
                    r_found_next  = 1'b0;
                    r_slot_next   = '0;
                    r_key_next    = '0;
                    r_status_next = ST_NOEFF;
                    state_next    = S_LOOK;
                end
            end

            S_LOOK:
            begin
                state_next = S_DONE;
                unique case (act_reg) inside
                    ACT_SEARCH, ACT_INSERT, ACT_REMOVE:
                    begin
                        if (key_oor)
                        begin
                            r_status_next = ST_REJECT;
                        end
                        else
                        begin
                            s_next     = sp_rdata;
                            dn_raddr   = sp_rdata;
                            state_next = S_CHK;
                        end
                    end
                    ACT_READ:
                    begin
                        if (32'(pos_reg) < 32'(cnt_reg))
                        begin
                            r_found_next  = 1'b1;
                            r_slot_next   = pos_reg;
                            r_key_next    = dn_rdata;
                            r_status_next = ST_DONE;
                        end
                    end
                    ACT_CLEAR:
                    begin
                        cnt_next      = '0;
                        r_status_next = ST_DONE;
                    end
                    default:
                    begin
                        r_status_next = ST_NOEFF;
                    end
                endcase
            end

            S_CHK:
            begin
                state_next = S_DONE;
                if (act_reg == ACT_INSERT)
                begin
                    if (hit)
                    begin
                        r_found_next  = 1'b1;
                        r_slot_next   = SLOT_W'(s_reg);
                        r_status_next = ST_NOEFF;
                    end
                    else if (cnt_reg >= NW'(CAPACITY))
                    begin
                        r_status_next = ST_REJECT;
                    end
                    else
                    begin
                        dn_we         = 1'b1;
                        sp_we         = 1'b1;
                        cnt_next      = cnt_reg + 1'b1;
                        r_found_next  = 1'b1;
                        r_slot_next   = SLOT_W'(cnt_reg);
                        r_status_next = ST_DONE;
                    end
                end
                else if (hit)
                begin
                    r_found_next  = 1'b1;
                    r_slot_next   = SLOT_W'(s_reg);
                    r_status_next = ST_DONE;
                    if (act_reg == ACT_REMOVE)
                    begin
                        // fetch the last member to fill the hole
                        dn_raddr   = SW'(cnt_reg - 1'b1);
                        state_next = S_RM;
                    end
                end
            end

            S_RM:
            begin
                dn_we      = 1'b1;
                dn_waddr   = s_reg;
                dn_wdata   = dn_rdata;
                sp_we      = 1'b1;
                sp_waddr   = KIW'(dn_rdata);
                sp_wdata   = s_reg;
                cnt_next   = cnt_reg - 1'b1;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    found_next     = r_found_reg;
                    slot_next      = r_slot_reg;
                    key_out_next   = r_key_reg;
                    count_next     = CNT_W'(cnt_reg);
                    status_next    = r_status_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_idx_reg   <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg      <= act_next;
        key_reg      <= key_next;
        pos_reg      <= pos_next;
        s_reg        <= s_next;
        r_found_reg  <= r_found_next;
        r_slot_reg   <= r_slot_next;
        r_key_reg    <= r_key_next;
        r_status_reg <= r_status_next;
        found_reg    <= found_next;
        slot_reg     <= slot_next;
        key_out_reg  <= key_out_next;
        count_reg    <= count_next;
        status_reg   <= status_next;
    end

    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign slot      = slot_reg;
    assign key_out   = key_out_reg;
    assign count     = count_reg;
    assign status    = status_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= NW'(CAPACITY))
        else $error("member count above capacity");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> in_stall)
        else $error("new word taken while previous one in flight");

    a_no_result_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLR) |-> !out_valid_reg)
        else $error("result issued during map sweep");

    a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RM) |=> (cnt_reg == $past(cnt_reg) - 1'b1))
        else $error("remove did not drop the count");

endmodule
